// ===== hdl/spf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

	// Default number of entries in each of the three queues.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Number of queues and their indexes, in priority order.
	localparam int NUM_QUEUES = 3;
	localparam logic [1:0] Q_TOP    = 2'd0;
	localparam logic [1:0] Q_MIDDLE = 2'd1;
	localparam logic [1:0] Q_LOWEST = 2'd2;

	// Class codes carried by an enqueue request.
	localparam logic [1:0] CLS_TOP    = 2'd1;
	localparam logic [1:0] CLS_MIDDLE = 2'd2;

	// Width of the reported queue fill counts.
	localparam int COUNT_OUT_W = 5;

	// Request kind.
	typedef enum logic {
		KIND_ENQUEUE = 1'b0,
		KIND_SERVE   = 1'b1
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_NOTHING  = 2'd2,
		ST_DROPPED  = 2'd3
	} status_t;

	// One stored queue entry: ticket and service code.
	typedef struct packed {
		logic [15:0] ticket;
		logic [2:0]  service;
	} entry_t;

	// Per-queue control from the scheduler to one queue.
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	// Service duration in minutes for each service code.
	function automatic logic [4:0] service_minutes_of(input logic [2:0] code);
		logic [4:0] mins;
		case (code)
			3'd0: mins = 5'd2;
			3'd1: mins = 5'd5;
			3'd2: mins = 5'd15;
			3'd3: mins = 5'd25;
			3'd4: mins = 5'd8;
			default: mins = 5'd5;
		endcase
		return mins;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/spf_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: valid/ready handshake with the request fields.
interface spf_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [1:0] prio_class;
	logic [2:0] service_code;

	modport source (output valid, kind, prio_class, service_code, input ready);
	modport sink (input valid, kind, prio_class, service_code, output ready);
endinterface

`default_nettype wire

// ===== hdl/spf_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result channel: valid/ready handshake with the result fields.
interface spf_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] ticket;
	logic [2:0]  served_service;
	logic [1:0]  served_class;
	logic [4:0]  service_minutes;
	logic [4:0]  top_count;
	logic [4:0]  middle_count;
	logic [4:0]  lowest_count;
	logic [15:0] served_total;

	modport source (
		output valid, status, ticket, served_service, served_class, service_minutes,
			top_count, middle_count, lowest_count, served_total,
		input ready
	);
	modport sink (
		input valid, status, ticket, served_service, served_class, service_minutes,
			top_count, middle_count, lowest_count, served_total,
		output ready
	);
endinterface

`default_nettype wire

// ===== hdl/strict_priority_three_fifo_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Strict-priority scheduler over three FIFO queues (top, middle, lowest).
// Channel req carries one request: kind 0 enqueues a request of class
// prio_class (1 top, 2 middle, anything else lowest) with its service_code
// and stamps it with the running ticket; kind 1 serves the head of the
// highest non-empty queue. Channel rsp returns exactly one result per
// request: status, ticket, served service and class, duration in minutes,
// the three fill counts after the request and the served total.
// Results are registered: the result appears in the output register on the
// cycle after the request is taken. One request per cycle is sustained, set
// by the single output register, which is refilled in the same cycle its
// result is taken. When the receiver stalls, the result holds and req.ready
// stays low until it is taken. Each queue holds QUEUE_DEPTH entries in a
// chain of cells; an enqueue into a full queue is dropped with status 3.
// Reset empties all queues, sets the next ticket to 1, clears the served
// total and leaves the output register empty.
module strict_priority_three_fifo_unit
	import spf_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	spf_req_if.sink   req,
	spf_rsp_if.source rsp
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	queue_ctl_t    ctl [NUM_QUEUES];
	entry_t        head [NUM_QUEUES];
	logic [CW-1:0] count [NUM_QUEUES];
	logic [CW-1:0] count_next [NUM_QUEUES];

	logic          accept;
	logic [1:0]    enq_q_sel;
	logic [1:0]    srv_q_sel;
	logic          any_ready;
	logic          enq_ok;
	logic          do_serve;
	entry_t        new_entry;
	entry_t        served_entry;
	status_t       status_d;
	logic [15:0]   ticket_d;
	logic [2:0]    service_d;
	logic [1:0]    class_d;
	logic [4:0]    minutes_d;

	logic [15:0]   next_ticket_q;
	logic [15:0]   served_q;
	logic          out_valid_q;
	status_t       status_q;
	logic [15:0]   ticket_q;
	logic [2:0]    service_q;
	logic [1:0]    class_q;
	logic [4:0]    minutes_q;
	logic [4:0]    cnt_out_q [NUM_QUEUES];
	logic [15:0]   total_q;

	// A request is taken whenever the output register is empty or being drained.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Queue chosen by an enqueue.
	always_comb begin
		case (req.prio_class)
			CLS_TOP:    enq_q_sel = Q_TOP;
			CLS_MIDDLE: enq_q_sel = Q_MIDDLE;
			default:    enq_q_sel = Q_LOWEST;
		endcase
	end

	// Highest non-empty queue for a serve.
	always_comb begin
		any_ready = 1'b1;
		if (count[Q_TOP] != '0) begin
			srv_q_sel = Q_TOP;
		end else if (count[Q_MIDDLE] != '0) begin
			srv_q_sel = Q_MIDDLE;
		end else begin
			srv_q_sel = Q_LOWEST;
			any_ready = (count[Q_LOWEST] != '0);
		end
	end

	assign enq_ok    = (count[enq_q_sel] != CW'(QUEUE_DEPTH));
	assign do_serve  = accept && (req.kind == KIND_SERVE) && any_ready;
	assign new_entry = '{ticket: next_ticket_q, service: req.service_code};
	assign served_entry = head[srv_q_sel];

	// Queue controls and fill counts after this request.
	always_comb begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			ctl[q].push = accept && (req.kind == KIND_ENQUEUE) && enq_ok
				&& (enq_q_sel == 2'(q));
			ctl[q].pop  = do_serve && (srv_q_sel == 2'(q));
			count_next[q] = count[q];
			if (ctl[q].push) begin
				count_next[q] = count[q] + CW'(1);
			end else if (ctl[q].pop) begin
				count_next[q] = count[q] - CW'(1);
			end
		end
	end

	// Three queues, each a chain of cells.
	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
		spf_queue #(
			.DEPTH (QUEUE_DEPTH)
		) u_queue (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[g]),
			.push_data (new_entry),
			.head      (head[g]),
			.count     (count[g])
		);
	end

	// Result fields of this request.
	always_comb begin
		ticket_d  = '0;
		service_d = '0;
		class_d   = '0;
		minutes_d = '0;
		if (req.kind == KIND_ENQUEUE) begin
			if (enq_ok) begin
				status_d = ST_ENQUEUED;
				ticket_d = next_ticket_q;
			end else begin
				status_d = ST_DROPPED;
			end
		end else if (any_ready) begin
			status_d  = ST_SERVED;
			ticket_d  = served_entry.ticket;
			service_d = served_entry.service;
			class_d   = srv_q_sel;
			minutes_d = service_minutes_of(served_entry.service);
		end else begin
			status_d = ST_NOTHING;
		end
	end

	// Ticket and served counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ticket_q <= 16'd1;
			served_q      <= '0;
		end else begin
			if (ctl[Q_TOP].push || ctl[Q_MIDDLE].push || ctl[Q_LOWEST].push) begin
				next_ticket_q <= next_ticket_q + 16'd1;
			end
			if (do_serve) begin
				served_q <= served_q + 16'd1;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.ready) begin
			out_valid_q <= accept;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			ticket_q  <= ticket_d;
			service_q <= service_d;
			class_q   <= class_d;
			minutes_q <= minutes_d;
			total_q   <= do_serve ? served_q + 16'd1 : served_q;
			for (int q = 0; q < NUM_QUEUES; q++) begin
				cnt_out_q[q] <= COUNT_OUT_W'(count_next[q]);
			end
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = status_q;
	assign rsp.ticket          = ticket_q;
	assign rsp.served_service  = service_q;
	assign rsp.served_class    = class_q;
	assign rsp.service_minutes = minutes_q;
	assign rsp.top_count       = cnt_out_q[Q_TOP];
	assign rsp.middle_count    = cnt_out_q[Q_MIDDLE];
	assign rsp.lowest_count    = cnt_out_q[Q_LOWEST];
	assign rsp.served_total    = total_q;

	// No queue ever holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count[Q_TOP] <= CW'(QUEUE_DEPTH) && count[Q_MIDDLE] <= CW'(QUEUE_DEPTH)
			&& count[Q_LOWEST] <= CW'(QUEUE_DEPTH))
	else $error("queue fill count above depth");

	// At most one queue is pushed or popped per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl[Q_TOP].push, ctl[Q_MIDDLE].push, ctl[Q_LOWEST].push,
			ctl[Q_TOP].pop, ctl[Q_MIDDLE].pop, ctl[Q_LOWEST].pop}))
	else $error("more than one queue operation in a cycle");

	// The served counter moves only on a successful serve.
	assert property (@(posedge clk) disable iff (!arst_n)
		!do_serve |=> $stable(served_q))
	else $error("served counter changed without a serve");

	// A serve result always carries the class of a queue that was not empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		do_serve |-> count[srv_q_sel] != '0)
	else $error("serve selected an empty queue");

endmodule

`default_nettype wire

// ===== hdl/spf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One storage cell of a queue chain. It either loads a new entry, takes the
// entry of its upstream neighbor when the chain advances, or holds.
module spf_cell
	import spf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   load,
	input  wire entry_t load_data,
	input  wire logic   shift,
	input  wire entry_t next_data,
	output entry_t      data_q
);

	// Entry register; payload only, so no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/spf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A FIFO built as a chain of cells. Cell 0 always holds the head. A pop moves
// every cell one place toward the head; a push loads the first free cell.
module spf_queue
	import spf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire queue_ctl_t ctl,
	input  wire entry_t     push_data,
	output entry_t          head,
	output logic [CW-1:0]   count
);

	entry_t        cell_data [DEPTH];
	logic [CW-1:0] count_q;

	// Row of cells; each takes its upstream neighbor on a pop.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t upstream;
		if (i == DEPTH - 1) begin : g_last
			assign upstream = '0;
		end else begin : g_mid
			assign upstream = cell_data[i + 1];
		end
		spf_cell u_cell (
			.clk       (clk),
			.load      (ctl.push && (count_q == CW'(i))),
			.load_data (push_data),
			.shift     (ctl.pop),
			.next_data (upstream),
			.data_q    (cell_data[i])
		);
	end

	// Fill count; push and pop never come in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign head  = cell_data[0];
	assign count = count_q;

endmodule

`default_nettype wire

// ===== dv/spf_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the request and result channels of the three-queue scheduler. It keeps its own
// copy of the queues, predicts one result per accepted request, and compares every
// accepted result, field by field, with the oldest prediction.
module spf_result_checker
	import spf_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spf_req_if        req,
	spf_rsp_if        rsp,
	output int        fail_count,
	output int        pending
);

	// One result as it appears on the result channel.
	typedef struct packed {
		status_t     status;
		logic [15:0] ticket;
		logic [2:0]  service;
		logic [1:0]  queue;
		logic [4:0]  minutes;
		logic [4:0]  top_fill;
		logic [4:0]  middle_fill;
		logic [4:0]  lowest_fill;
		logic [15:0] total;
	} outcome_t;

	// Service duration for each service code.
	localparam logic [4:0] MINUTES_BY_CODE [8] = '{
		5'd2, 5'd5, 5'd15, 5'd25, 5'd8, 5'd5, 5'd5, 5'd5
	};

	// Shadow queues in priority order, plus the ticket and served counters.
	entry_t      lines [NUM_QUEUES][$];
	logic [15:0] ticket_next;
	logic [15:0] served_so_far;

	// Results predicted but not yet seen on the result channel.
	outcome_t    awaited_results [$];

	// Print one line for each of the first 100 mismatches, and count every mismatch.
	task automatic report_mismatch(input string what);
		if (fail_count < 100) begin
			$display("%0t ns: mismatch: %s", $realtime, what);
		end
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
		end
	endtask

	// Apply one request to the shadow queues and work out the result it causes.
	function automatic outcome_t schedule_request(input kind_t kind, input logic [1:0] cls,
			input logic [2:0] svc);
		outcome_t o;
		int       q;
		entry_t   e;
		o = '0;
		if (kind == KIND_ENQUEUE) begin
			q = (cls == CLS_TOP) ? Q_TOP : (cls == CLS_MIDDLE) ? Q_MIDDLE : Q_LOWEST;
			if (lines[q].size() >= DEPTH) begin
				// A full queue drops the request and keeps the ticket.
				o.status = ST_DROPPED;
			end else begin
				e.ticket  = ticket_next;
				e.service = svc;
				lines[q].insert(lines[q].size(), e);
				o.status    = ST_ENQUEUED;
				o.ticket    = ticket_next;
				ticket_next = ticket_next + 16'd1;
			end
		end else begin
			// The lowest index among non-empty queues wins.
			q = NUM_QUEUES;
			for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
				if (lines[i].size() != 0) begin
					q = i;
				end
			end
			if (q == NUM_QUEUES) begin
				o.status = ST_NOTHING;
			end else begin
				e             = lines[q].pop_front();
				served_so_far = served_so_far + 16'd1;
				o.status      = ST_SERVED;
				o.ticket      = e.ticket;
				o.service     = e.service;
				o.queue       = 2'(q);
				o.minutes     = MINUTES_BY_CODE[e.service];
			end
		end
		o.top_fill    = 5'(lines[Q_TOP].size());
		o.middle_fill = 5'(lines[Q_MIDDLE].size());
		o.lowest_fill = 5'(lines[Q_LOWEST].size());
		o.total       = served_so_far;
		return o;
	endfunction

	// Compare results with the oldest prediction, then predict for a new request.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				lines[i].delete();
			end
			awaited_results.delete();
			ticket_next   = 16'd1;
			served_so_far = 16'd0;
			fail_count    = 0;
			pending       = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no request waiting for it");
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 16'(rsp.status), 16'(want.status));
					check_field("ticket", rsp.ticket, want.ticket);
					check_field("served_service", 16'(rsp.served_service),
						16'(want.service));
					check_field("served_class", 16'(rsp.served_class), 16'(want.queue));
					check_field("service_minutes", 16'(rsp.service_minutes),
						16'(want.minutes));
					check_field("top_count", 16'(rsp.top_count), 16'(want.top_fill));
					check_field("middle_count", 16'(rsp.middle_count),
						16'(want.middle_fill));
					check_field("lowest_count", 16'(rsp.lowest_count),
						16'(want.lowest_fill));
					check_field("served_total", rsp.served_total, want.total);
				end
			end
			if (req.valid && req.ready) begin
				awaited_results.insert(awaited_results.size(),
					schedule_request(kind_t'(req.kind), req.prio_class,
					req.service_code));
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== dv/tb_strict_priority_three_fifo_unit.sv =====
`timescale 1ns / 1ps

module tb_strict_priority_three_fifo_unit;
	import spf_pkg::*;

	localparam int LONG_HOLD = 100;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   idle_en;
	bit   sink_hold_req;

	spf_req_if req_ch ();
	spf_rsp_if rsp_ch ();

	strict_priority_three_fifo_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	spf_result_checker #(
		.DEPTH(QUEUE_DEPTH_DEF)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap length: mostly short, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Offer one request, with an optional idle gap in front, and wait until it is taken.
	task automatic send_req(input kind_t kind, input logic [1:0] cls, input logic [2:0] svc);
		int gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 99) < 30) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= kind;
		req_ch.prio_class   <= cls;
		req_ch.service_code <= svc;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has arrived.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Random traffic in bursts: fills of one class, drains, mixed requests and noise.
	task automatic run_random(input int count);
		int         sent;
		int         pick;
		int         burst;
		logic [1:0] cls;
		sent = 0;
		while (sent < count) begin
			pick  = $urandom_range(0, 99);
			burst = $urandom_range(1, 20);
			cls   = 2'($urandom_range(0, 3));
			for (int i = 0; i < burst && sent < count; i++) begin
				if (pick < 35) begin
					send_req(KIND_ENQUEUE, cls, 3'($urandom_range(0, 7)));
				end else if (pick < 60) begin
					send_req(KIND_SERVE, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
				end else if (pick < 90) begin
					send_req(($urandom_range(0, 9) < 6) ? KIND_ENQUEUE : KIND_SERVE,
						2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
				end else begin
					send_req(kind_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
						3'($urandom_range(0, 7)));
				end
				sent++;
			end
		end
	endtask

	// Result receiver: random stalls, plus one long hold when asked.
	initial begin
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				hold_left     = LONG_HOLD;
				sink_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idle_en && $urandom_range(0, 99) < 25) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		req_ch.valid        = 1'b0;
		req_ch.kind         = KIND_ENQUEUE;
		req_ch.prio_class   = 2'd0;
		req_ch.service_code = 3'd0;
		idle_en             = 1'b0;
		sink_hold_req       = 1'b0;
		arst_n              = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Serve on empty queues, every class and service code, priority order on the way
		// out, then empty again.
		send_req(KIND_SERVE, 2'd0, 3'd0);
		send_req(KIND_ENQUEUE, 2'd1, 3'd0);
		send_req(KIND_ENQUEUE, 2'd2, 3'd1);
		send_req(KIND_ENQUEUE, 2'd0, 3'd2);
		send_req(KIND_ENQUEUE, 2'd3, 3'd3);
		send_req(KIND_ENQUEUE, 2'd1, 3'd4);
		send_req(KIND_ENQUEUE, 2'd2, 3'd5);
		send_req(KIND_ENQUEUE, 2'd0, 3'd6);
		send_req(KIND_ENQUEUE, 2'd3, 3'd7);
		repeat (8) send_req(KIND_SERVE, 2'd3, 3'd7);
		send_req(KIND_SERVE, 2'd3, 3'd7);
		send_req(KIND_ENQUEUE, 2'd3, 3'd7);
		send_req(KIND_SERVE, 2'd0, 3'd0);
		wait_drained();

		// Random traffic with idling on both sides.
		idle_en = 1'b1;
		run_random(400);
		wait_drained();

		// The receiver holds off for a long stretch while requests keep coming.
		sink_hold_req = 1'b1;
		run_random(400);
		wait_drained();

		// Back-to-back traffic with no idling.
		idle_en = 1'b0;
		run_random(400);
		wait_drained();

		// More random traffic with idling on both sides.
		idle_en = 1'b1;
		run_random(400);
		wait_drained();
		repeat (20) @(negedge clk);

		if (fail_count == 0) begin
			$display("strict_priority_three_fifo_unit regression: pass");
		end else begin
			$display("strict_priority_three_fifo_unit regression: fail");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#8_000_000;
		$display("strict_priority_three_fifo_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/spf_pkg.sv
hdl/spf_req_if.sv
hdl/spf_rsp_if.sv
hdl/spf_cell.sv
hdl/spf_queue.sv
hdl/strict_priority_three_fifo_unit.sv
dv/spf_result_checker.sv
dv/tb_strict_priority_three_fifo_unit.sv
